FILE: hdl/sase_pkg.sv
package sase_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;

  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_ERASE    = 3'd1;
  localparam logic [OP_W-1:0] OP_LOWER    = 3'd2;
  localparam logic [OP_W-1:0] OP_POP      = 3'd3;
  localparam logic [OP_W-1:0] OP_ERASE_AT = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_AT  = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd6;

  localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd3;

  localparam logic [1:0] SHIFT_HOLD   = 2'd0;
  localparam logic [1:0] SHIFT_INSERT = 2'd1;
  localparam logic [1:0] SHIFT_ERASE  = 2'd2;

  // Command broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic             cmp_en;
    logic [1:0]       shift_mode;
    logic [IDX_W-1:0] at;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] key;
  } sase_cmd_t;

endpackage

FILE: hdl/sase_if.sv
interface sase_in_if import sase_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [VAL_W-1:0] key_value;
  logic [IDX_W-1:0]        position;

  modport source (output valid, output op, output key_value, output position, input ready);
  modport sink   (input valid, input op, input key_value, input position, output ready);
endinterface

interface sase_out_if import sase_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic [CNT_W-1:0]        found_position;
  logic signed [VAL_W-1:0] read_value;
  logic [CNT_W-1:0]        entry_count;
  logic                    is_empty;

  modport source (output valid, output status, output found_position, output read_value,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input status, input found_position, input read_value,
                  input entry_count, input is_empty, output ready);
endinterface

FILE: hdl/sorted_array_set_engine.sv
// Sorted set engine: keeps up to 256 distinct signed 32-bit values in
// ascending order in a row of cells, one value per cell, with a stored count.
// Each accepted item carries one operation (insert, erase by value, lower
// bound, pop largest, erase at position, read at position, clear) and yields
// exactly one result item with status, position, value, count and empty flag.
// An item passes through the sequencer states in order: the accepting edge
// captures it, then come a parallel compare in every cell, locating the lower
// bound from the cells' flags, reading the addressed cell, and a shift of the
// row together with the write of the result into the output register. The
// sequencer handles one item at a time, so it takes no new item until the
// current one is through. The input is ready again only once the output
// register is empty or its result is taken in the same cycle, so a receiver
// that holds off also holds off the next item.
// After reset the table is empty and no clearing pass is needed.
module sorted_array_set_engine import sase_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  sase_in_if.sink       in_ch,
  sase_out_if.source    out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_LOC  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EXE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [OP_W-1:0]  op_r;
  logic [VAL_W-1:0] key_r;
  logic [IDX_W-1:0] pos_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] p_r, p_nxt;
  logic [VAL_W-1:0] rd_r;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r, status_nxt;
  logic [CNT_W-1:0] out_fpos_r, fpos_nxt;
  logic [VAL_W-1:0] out_val_r, val_nxt;
  logic [CNT_W-1:0] out_count_r;

  logic             accept;
  logic [1:0]       shift_mode;
  logic             in_range;
  logic             hit;
  sase_cmd_t        cmd;

  logic [VAL_W-1:0]    vals    [CAPACITY];
  logic [VAL_W-1:0]    rd_vals [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CNT_W-1:0]    lb_pos;
  logic [VAL_W-1:0]    sel_val;

  // A new item is taken only when the sequencer is idle and the output
  // register is free or being emptied at the same edge.
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // Every cell sees the same command; the position is the located one.
  assign cmd.cmp_en     = (state_r == S_CMP);
  assign cmd.shift_mode = shift_mode;
  assign cmd.at         = p_r[IDX_W-1:0];
  assign cmd.count      = count_r;
  assign cmd.key        = key_r;

  // The cell row: each cell passes its value to both neighbors so the row can
  // open or close a gap with all cells moving together.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cells
    logic [VAL_W-1:0] prev_v;
    logic [VAL_W-1:0] next_v;
    if (g == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_prev
      assign prev_v = vals[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_next
      assign next_v = vals[g+1];
    end
    sase_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .cell_idx (IDX_W'(g)),
      .prev_val (prev_v),
      .next_val (next_v),
      .value    (vals[g]),
      .lt       (lt_vec[g]),
      .rd_val   (rd_vals[g])
    );
  end

  sase_gather u_gather (
    .lt_vec  (lt_vec),
    .rd_vals (rd_vals),
    .lb_pos  (lb_pos),
    .sel_val (sel_val)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP:   state_nxt = S_LOC;
      S_LOC:   state_nxt = S_RD;
      S_RD:    state_nxt = S_EXE;
      S_EXE:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // The working position: the lower bound for value operations, the last
  // occupied cell for a pop, and the requested position for erase and read at a position.
  always_comb begin
    case (op_r)
      OP_POP:      p_nxt = (count_r == '0) ? '0 : count_r - CNT_W'(1);
      OP_ERASE_AT: p_nxt = {1'b0, pos_r};
      OP_READ_AT:  p_nxt = {1'b0, pos_r};
      default:     p_nxt = lb_pos;
    endcase
  end

  assign in_range = p_r < count_r;
  assign hit      = in_range && (rd_r == key_r);

  // Result and row update, evaluated in the last step of an item.
  always_comb begin
    status_nxt = ST_DONE;
    fpos_nxt   = '0;
    val_nxt    = '0;
    count_nxt  = count_r;
    shift_mode = SHIFT_HOLD;
    if (state_r == S_EXE) begin
      case (op_r)
        OP_INSERT: begin
          fpos_nxt = p_r;
          if (hit) begin
            status_nxt = ST_MISS;
            val_nxt    = key_r;
          end else if (count_r >= CNT_W'(CAPACITY)) begin
            status_nxt = ST_FULL;
          end else begin
            shift_mode = SHIFT_INSERT;
            count_nxt  = count_r + CNT_W'(1);
            val_nxt    = key_r;
          end
        end
        OP_ERASE: begin
          fpos_nxt = p_r;
          if (hit) begin
            shift_mode = SHIFT_ERASE;
            count_nxt  = count_r - CNT_W'(1);
            val_nxt    = key_r;
          end else begin
            status_nxt = ST_MISS;
          end
        end
        OP_LOWER: begin
          fpos_nxt = p_r;
          if (in_range) begin
            val_nxt = rd_r;
          end else begin
            status_nxt = ST_MISS;
          end
        end
        OP_POP: begin
          if (count_r == '0) begin
            status_nxt = ST_RANGE;
          end else begin
            fpos_nxt  = p_r;
            val_nxt   = rd_r;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        OP_ERASE_AT: begin
          fpos_nxt = p_r;
          if (in_range) begin
            shift_mode = SHIFT_ERASE;
            count_nxt  = count_r - CNT_W'(1);
            val_nxt    = rd_r;
          end else begin
            status_nxt = ST_RANGE;
          end
        end
        OP_READ_AT: begin
          fpos_nxt = p_r;
          if (in_range) begin
            val_nxt = rd_r;
          end else begin
            status_nxt = ST_RANGE;
          end
        end
        OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_EXE) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item payload and intermediate results.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_ch.op;
      key_r <= in_ch.key_value;
      pos_r <= in_ch.position;
    end
    if (state_r == S_LOC) begin
      p_r <= p_nxt;
    end
    if (state_r == S_RD) begin
      rd_r <= sel_val;
    end
    if (state_r == S_EXE) begin
      out_status_r <= status_nxt;
      out_fpos_r   <= fpos_nxt;
      out_val_r    <= val_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found_position = out_fpos_r;
  assign out_ch.read_value     = out_val_r;
  assign out_ch.entry_count    = out_count_r;
  assign out_ch.is_empty       = (out_count_r == '0);

endmodule

FILE: hdl/sase_cell.sv
module sase_cell import sase_pkg::*; (
  input  logic             clk,
  input  sase_cmd_t        cmd,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [VAL_W-1:0] prev_val,
  input  logic [VAL_W-1:0] next_val,
  output logic [VAL_W-1:0] value,
  output logic             lt,
  output logic [VAL_W-1:0] rd_val
);

  logic [VAL_W-1:0] value_r;
  logic             lt_r;
  logic             occupied;
  logic             less;

  assign occupied = {1'b0, cell_idx} < cmd.count;
  assign less     = $signed(value_r) < $signed(cmd.key);

  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      lt_r <= occupied && less;
    end
    case (cmd.shift_mode)
      SHIFT_INSERT: begin
        if (cell_idx > cmd.at) begin
          value_r <= prev_val;
        end else if (cell_idx == cmd.at) begin
          value_r <= cmd.key;
        end
      end
      SHIFT_ERASE: begin
        if (cell_idx >= cmd.at) begin
          value_r <= next_val;
        end
      end
      default: begin
      end
    endcase
  end

  assign value  = value_r;
  assign lt     = lt_r;
  assign rd_val = (cell_idx == cmd.at) ? value_r : '0;

endmodule

FILE: hdl/sase_gather.sv
module sase_gather import sase_pkg::*; (
  input  logic [CAPACITY-1:0] lt_vec,
  input  logic [VAL_W-1:0]    rd_vals [CAPACITY],
  output logic [CNT_W-1:0]    lb_pos,
  output logic [VAL_W-1:0]    sel_val
);

  // The less-than flags form a thermometer code: the lower bound is the single
  // set-to-clear step, 0 with no flag set, CAPACITY with every flag set.
  always_comb begin
    lb_pos  = '0;
    sel_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_val = sel_val | rd_vals[i];
      if (i == 0) begin
        if (!lt_vec[0]) begin
          lb_pos = lb_pos | '0;
        end
      end else if (lt_vec[i-1] && !lt_vec[i]) begin
        lb_pos = lb_pos | CNT_W'(i);
      end
    end
    if (lt_vec[CAPACITY-1]) begin
      lb_pos = CNT_W'(CAPACITY);
    end
  end

endmodule
